/* sv/tts_pkg.sv */
// Package for the tridiagonal Thomas solver core: payload types, sizes, states.
// No dependencies.
package tts_pkg;

    localparam int MAX_ROWS = 64;
    localparam int ADDR_W   = $clog2(MAX_ROWS);
    localparam int CNT_W    = $clog2(MAX_ROWS + 1);

    typedef struct packed {
        logic signed [31:0] lower_coef;
        logic signed [31:0] diag_coef;
        logic signed [31:0] upper_coef;
        logic signed [31:0] rhs_value;
        logic               last_row;
    } tts_in_t;

    typedef struct packed {
        logic signed [31:0] x_value;
        logic [5:0]         row_index;
        logic               is_last;
        logic               zero_pivot;
    } tts_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FRD,     // forward: read previous row
        ST_FDIV,    // forward: m = lower / d'
        ST_FMUL1,   // forward: m*c and m*b'
        ST_FWR,     // forward: write row
        ST_BRD,     // backward: read row i
        ST_BWAIT,
        ST_BMUL,    // backward: start (b' - c*x) / d'
        ST_BDIV,    // backward: x = (b' - c*x) / d'
        ST_BOUT     // backward: present result
    } tts_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)       return 32'sh7fffffff;
        else if (v < -66'sd2147483648) return 32'sh80000000;
        else                           return v[31:0];
    endfunction

    // Q16.16 product, truncated toward zero, saturated.
    function automatic logic signed [31:0] q_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] p;
        logic signed [65:0] q;
        p = a * b;
        q = 66'(p);
        if (p < 0) q = q + 66'sd65535;
        q = q >>> 16;
        return sat32(q);
    endfunction

    function automatic logic signed [31:0] q_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return sat32(66'(a) - 66'(b));
    endfunction

endpackage

/* sv/tts_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module tts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read before write: the registered read returns the old word.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* sv/tts_div.sv */
// Iterative Q16.16 divider: (a*65536)/b truncated toward zero, saturated.
// Uses tts_pkg; one quotient bit per cycle over 48 bits.
module tts_div
    import tts_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [31:0] quot,
    output logic               div_zero
);

    logic [47:0] dvd_reg;
    logic [47:0] q_reg;
    logic [32:0] rem_reg;
    logic [31:0] dsr_reg;
    logic        neg_reg;
    logic        zero_reg;
    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic [47:0] mag_na;
    logic signed [65:0] sq;

    assign trial = {rem_reg[31:0], dvd_reg[47]} - {1'b0, dsr_reg};

    always_comb begin
        mag_na = num[31] ? 48'(-{num[31], num}) << 16 : 48'({1'b0, num}) << 16;
    end

    // Restoring division, one bit per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                dvd_reg  <= mag_na;
                dsr_reg  <= den[31] ? 32'(-{den[31], den}) : den;
                neg_reg  <= num[31] ^ den[31];
                zero_reg <= (den == 32'sd0);
                rem_reg  <= '0;
                q_reg    <= '0;
                cnt_reg  <= 6'd48;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                dvd_reg <= dvd_reg << 1;
                if (!trial[32]) begin
                    rem_reg <= trial;
                    q_reg   <= {q_reg[46:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[31:0], dvd_reg[47]};
                    q_reg   <= {q_reg[46:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign sq       = neg_reg ? -66'($unsigned(q_reg)) : 66'($unsigned(q_reg));
    assign done     = done_reg;
    assign div_zero = zero_reg;
    assign quot     = zero_reg ? 32'sd0 : sat32(sq);

endmodule

/* sv/tridiagonal_thomas_solver_core.sv */
// Tridiagonal Thomas solver core, signed Q16.16 with saturation.
// Each row is accepted only in idle and is stored before the next is taken, waiting on the
// 48-step iterative divider except for the first row; a row on a full store is dropped.
// After the last row, each result waits on a memory read and the divider, and results
// are emitted from the highest index down to 0.
// Synchronous active-low reset clears row count, error flag and control.
// Uses tts_pkg, tts_ram and tts_div.
module tridiagonal_thomas_solver_core
    import tts_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tts_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output tts_out_t m_data
);

    tts_state_t state_reg, state_next;
    tts_in_t    row_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic              err_reg;
    logic signed [31:0] m_reg, x_reg, t_reg, dg_reg, rh_reg;
    logic signed [31:0] pd_reg, pr_reg, pu_reg;
    logic              mv_reg;
    tts_out_t          mo_reg;

    logic              we;
    logic [ADDR_W-1:0] addr;
    logic signed [31:0] rd_d, rd_r, rd_u;
    logic              dstart;
    logic signed [31:0] dnum, dden, dq;
    logic              ddone, dzero;

    tts_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_diag (
        .aclk(aclk), .we(we), .addr(addr), .wdata(dg_reg), .rdata(rd_d));
    tts_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_rhs (
        .aclk(aclk), .we(we), .addr(addr), .wdata(rh_reg), .rdata(rd_r));
    tts_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_upper (
        .aclk(aclk), .we(we), .addr(addr), .wdata(row_reg.upper_coef), .rdata(rd_u));

    tts_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dstart), .num(dnum), .den(dden),
        .done(ddone), .quot(dq), .div_zero(dzero));

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mv_reg;
    assign m_data  = mo_reg;

    // Next state and datapath controls.
    always_comb begin
        state_next = state_reg;
        we     = 1'b0;
        addr   = idx_reg;
        dstart = 1'b0;
        dnum   = row_reg.lower_coef;
        dden   = pd_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_FRD;
            ST_FRD: begin
                addr = ADDR_W'(cnt_reg - CNT_W'(1));
                if (cnt_reg == CNT_W'(MAX_ROWS)) begin
                    state_next = row_reg.last_row ? ST_BRD : ST_IDLE;
                end else if (cnt_reg == '0) begin
                    state_next = ST_FWR;
                end else begin
                    state_next = ST_FDIV;
                end
            end
            ST_FDIV: begin
                dstart = 1'b1;
                dden   = rd_d;
                state_next = ST_FMUL1;
            end
            ST_FMUL1: if (ddone) state_next = ST_FWR;
            ST_FWR: begin
                addr = ADDR_W'(cnt_reg);
                we   = 1'b1;
                state_next = row_reg.last_row ? ST_BRD : ST_IDLE;
            end
            ST_BRD: state_next = ST_BWAIT;
            ST_BWAIT: state_next = ST_BMUL;
            ST_BMUL: begin
                dstart = 1'b1;
                dnum   = t_reg;
                dden   = pd_reg;
                state_next = ST_BDIV;
            end
            ST_BDIV: if (ddone) state_next = ST_BOUT;
            ST_BOUT: begin
                if (!mv_reg || m_ready) begin
                    state_next = (idx_reg == '0) ? ST_IDLE : ST_BRD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            err_reg <= 1'b0;
            mv_reg  <= 1'b0;
        end else begin
            if (mv_reg && m_ready && state_reg != ST_BOUT) mv_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) row_reg <= s_data;
                    dg_reg <= s_data.diag_coef;
                    rh_reg <= s_data.rhs_value;
                end
                ST_FRD: begin
                    if (cnt_reg == CNT_W'(MAX_ROWS)) idx_reg <= ADDR_W'(MAX_ROWS - 1);
                    else idx_reg <= ADDR_W'(cnt_reg);
                end
                ST_FDIV: begin
                    pd_reg <= rd_d;
                    pr_reg <= rd_r;
                    pu_reg <= rd_u;
                end
                ST_FMUL1: begin
                    if (ddone) begin
                        if (dzero) err_reg <= 1'b1;
                        dg_reg <= q_sub(row_reg.diag_coef, q_mul(dq, pu_reg));
                        rh_reg <= q_sub(row_reg.rhs_value, q_mul(dq, pr_reg));
                    end
                end
                ST_FWR: begin
                    // A stored zero pivot will be divided by during the solve, so the
                    // flag is known before the first result goes out.
                    if (dg_reg == 32'sd0) err_reg <= 1'b1;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                ST_BRD: ;
                ST_BWAIT: begin
                    pd_reg <= rd_d;
                    // top row uses b' directly
                    if (idx_reg == ADDR_W'(cnt_reg - CNT_W'(1))) t_reg <= rd_r;
                    else t_reg <= q_sub(rd_r, q_mul(rd_u, x_reg));
                end
                ST_BMUL: ;
                ST_BDIV: begin
                    if (ddone) begin
                        x_reg <= dq;
                        if (dzero) err_reg <= 1'b1;
                    end
                end
                ST_BOUT: begin
                    if (!mv_reg || m_ready) begin
                        mv_reg            <= 1'b1;
                        mo_reg.x_value    <= x_reg;
                        mo_reg.row_index  <= 6'(idx_reg);
                        mo_reg.is_last    <= (idx_reg == '0);
                        mo_reg.zero_pivot <= err_reg;
                        if (idx_reg == '0) begin
                            cnt_reg <= '0;
                            err_reg <= 1'b0;
                        end else begin
                            idx_reg <= idx_reg - ADDR_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
